>>> hw/rtl/lir_pkg.sv
// Shared types, widths and codes for the linear interpolation resampler.
// No dependencies; every other file of the block imports this package.
package lir_pkg;

   localparam int SAMPLE_BITS      = 16;
   localparam int MAX_UPSAMPLE_DEF = 16;
   localparam int RATE_W           = 20;
   localparam int IDX_W            = 32;
   localparam int CSR_IDX_W        = 1;

   localparam int DIFF_W  = SAMPLE_BITS + 1;
   localparam int MUL_A_W = IDX_W + 1;
   localparam int NUM_W   = MUL_A_W + RATE_W;
   localparam int INT_W   = DIFF_W + RATE_W;
   localparam int ADV_W   = RATE_W + 1;
   localparam int SKADV_W = 2 * RATE_W + 1;
   localparam int DCNT_W  = $clog2(NUM_W + 1);

   localparam logic [CSR_IDX_W-1:0] REG_INPUT_RATE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_RATE = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      MUL_CAP,
      MUL_INTERP,
      MUL_SKIP
   } mul_sel_type;

   typedef enum logic [2:0] {
      DIV_CAP,
      DIV_INTERP,
      DIV_ADV,
      DIV_SKIP,
      DIV_SKADV
   } div_sel_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          buffer_last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          run_last;
      logic                          buffer_end;
   } rsp_type;

   typedef struct packed {
      logic        take;
      logic        mul_go;
      mul_sel_type mul_sel;
      logic        div_go;
      div_sel_type div_sel;
      logic        cap_load;
      logic        cnt_clear;
      logic        emit;
      logic        adv_load;
      logic        m_load;
      logic        finish;
      logic        phase;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic on_base;
      logic run_more;
      logic push_ok;
      logic pend_valid;
      logic seen_zero;
      logic last;
   } sts_type;

endpackage

>>> hw/rtl/lir_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, left-aligned numerator.
// Depends on lir_pkg.
module lir_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lir_pkg::NUM_W-1:0]   num,
   input  logic [lir_pkg::DCNT_W-1:0]  nbits,
   input  logic [lir_pkg::RATE_W-1:0]  den,
   output logic                        busy,
   output logic [lir_pkg::NUM_W-1:0]   quo,
   output logic [lir_pkg::RATE_W-1:0]  rem
);
   import lir_pkg::*;

   logic                busy_ff;
   logic [DCNT_W-1:0]   cnt_ff;
   logic [NUM_W-1:0]    q_ff, q_in;
   logic [RATE_W-1:0]   r_ff, r_in;
   logic [RATE_W-1:0]   d_ff;
   logic [RATE_W:0]     trial;
   logic [RATE_W:0]     trial_sub;
   logic                ge;

   always_comb begin
      trial     = {r_ff, q_ff[NUM_W-1]};
      trial_sub = trial - {1'b0, d_ff};
      ge        = trial >= {1'b0, d_ff};
      r_in      = ge ? trial_sub[RATE_W-1:0] : trial[RATE_W-1:0];
      q_in      = {q_ff[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= nbits;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= num;
         r_ff <= '0;
         d_ff <= den;
      end else if (busy_ff) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign busy = busy_ff;
   assign quo  = q_ff;
   assign rem  = r_ff;

endmodule

>>> hw/rtl/lir_dp.sv
// Datapath: rate registers, stream phase state, shared multiplier and divider,
// pending result slot and output register. Depends on lir_pkg and lir_div.
module lir_dp #(
   parameter int MAX_UPSAMPLE = lir_pkg::MAX_UPSAMPLE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [lir_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lir_pkg::RATE_W-1:0]     csr_wdata,
   input  lir_pkg::req_type               req_data,
   input  lir_pkg::cmd_type               cmd,
   output lir_pkg::sts_type               sts,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lir_pkg::rsp_type               rsp_data
);
   import lir_pkg::*;

   localparam int CNT_W = $clog2(MAX_UPSAMPLE + 1);

   function automatic logic [RATE_W-1:0] rate_of(input logic [RATE_W-1:0] v);
      return (v == '0) ? RATE_W'(1) : v;
   endfunction

   logic [RATE_W-1:0]      ir_ff, orr_ff;
   logic [SAMPLE_BITS-1:0] prev_ff, cur_ff;
   logic                   last_ff;
   logic [IDX_W-1:0]       seen_ff, given_ff, base_ff;
   logic [RATE_W-1:0]      res_ff, m_ff;
   logic [NUM_W-1:0]       cap_ff, mul_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   pend_valid_ff;
   logic [SAMPLE_BITS-1:0] pend_ff;
   logic                   out_valid_ff;
   rsp_type                out_ff;

   logic [IDX_W-1:0]       target;
   logic [SAMPLE_BITS-1:0] a_s;
   logic [DIFF_W-1:0]      diff, mag;
   logic                   neg;
   logic [MUL_A_W-1:0]     mul_a;
   logic [RATE_W-1:0]      mul_b;
   logic [ADV_W-1:0]       adv_sum;
   logic [SKADV_W-1:0]     skadv_sum;
   logic [NUM_W-1:0]       div_num;
   logic [DCNT_W-1:0]      div_nbits;
   logic [RATE_W-1:0]      div_den;
   logic                   div_busy;
   logic [NUM_W-1:0]       quo;
   logic [RATE_W-1:0]      rem;
   logic [DIFF_W:0]        qmag, vsum;
   logic                   out_load;
   logic                   push_ok;

   always_comb begin
      target = cmd.phase ? seen_ff : seen_ff - IDX_W'(1);
      a_s    = cmd.phase ? cur_ff : prev_ff;
      diff   = {cur_ff[SAMPLE_BITS-1], cur_ff} - {a_s[SAMPLE_BITS-1], a_s};
      neg    = diff[DIFF_W-1];
      mag    = neg ? (~diff + 1'b1) : diff;

      case (cmd.mul_sel)
         MUL_CAP: begin
            mul_a = MUL_A_W'(seen_ff) + MUL_A_W'(1);
            mul_b = orr_ff;
         end
         MUL_INTERP: begin
            mul_a = MUL_A_W'(mag);
            mul_b = res_ff;
         end
         MUL_SKIP: begin
            mul_a = MUL_A_W'(m_ff);
            mul_b = ir_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      adv_sum   = ADV_W'(res_ff) + ADV_W'(ir_ff);
      skadv_sum = SKADV_W'(res_ff) + mul_ff[SKADV_W-1:0];

      case (cmd.div_sel)
         DIV_CAP: begin
            div_num   = mul_ff;
            div_nbits = DCNT_W'(NUM_W);
            div_den   = ir_ff;
         end
         DIV_INTERP: begin
            div_num   = {mul_ff[INT_W-1:0], {(NUM_W-INT_W){1'b0}}};
            div_nbits = DCNT_W'(INT_W);
            div_den   = orr_ff;
         end
         DIV_ADV: begin
            div_num   = {adv_sum, {(NUM_W-ADV_W){1'b0}}};
            div_nbits = DCNT_W'(ADV_W);
            div_den   = orr_ff;
         end
         DIV_SKIP: begin
            div_num   = {orr_ff - res_ff, {(NUM_W-RATE_W){1'b0}}};
            div_nbits = DCNT_W'(RATE_W);
            div_den   = ir_ff;
         end
         DIV_SKADV: begin
            div_num   = {skadv_sum, {(NUM_W-SKADV_W){1'b0}}};
            div_nbits = DCNT_W'(SKADV_W);
            div_den   = orr_ff;
         end
         default: begin
            div_num   = '0;
            div_nbits = '0;
            div_den   = orr_ff;
         end
      endcase

      // floor division: negative spans round away from zero
      qmag = {1'b0, quo[DIFF_W-1:0]} + (DIFF_W+1)'(neg && (rem != '0));
      vsum = {{(DIFF_W+1-SAMPLE_BITS){a_s[SAMPLE_BITS-1]}}, a_s}
           + (neg ? (~qmag + 1'b1) : qmag);
   end

   lir_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_go),
      .num   (div_num),
      .nbits (div_nbits),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (quo),
      .rem   (rem)
   );

   assign push_ok  = !out_valid_ff || rsp_ready;
   assign out_load = (cmd.emit || cmd.finish) && pend_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ir_ff         <= RATE_W'(1);
         orr_ff        <= RATE_W'(1);
         prev_ff       <= '0;
         seen_ff       <= '0;
         given_ff      <= '0;
         res_ff        <= '0;
         base_ff       <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_INPUT_RATE:  ir_ff  <= rate_of(csr_wdata);
               REG_OUTPUT_RATE: orr_ff <= rate_of(csr_wdata);
               default: ;
            endcase
            prev_ff  <= '0;
            seen_ff  <= '0;
            given_ff <= '0;
            res_ff   <= '0;
            base_ff  <= '0;
         end
         if (cmd.cnt_clear) begin
            cnt_ff <= '0;
         end
         if (cmd.emit) begin
            pend_valid_ff <= 1'b1;
            given_ff      <= given_ff + IDX_W'(1);
            cnt_ff        <= cnt_ff + CNT_W'(1);
         end
         if (cmd.adv_load) begin
            base_ff <= base_ff + quo[IDX_W-1:0];
            res_ff  <= rem;
         end
         if (cmd.finish) begin
            pend_valid_ff <= 1'b0;
            if (last_ff) begin
               prev_ff  <= '0;
               seen_ff  <= '0;
               given_ff <= '0;
               res_ff   <= '0;
               base_ff  <= '0;
            end else begin
               prev_ff <= cur_ff;
               seen_ff <= seen_ff + IDX_W'(1);
            end
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         cur_ff  <= req_data.sample_in;
         last_ff <= req_data.buffer_last;
      end
      if (cmd.mul_go) begin
         mul_ff <= mul_a * mul_b;
      end
      if (cmd.cap_load) begin
         cap_ff <= quo;
      end
      if (cmd.m_load) begin
         m_ff <= quo[RATE_W-1:0] + RATE_W'(rem != '0);
      end
      if (cmd.emit) begin
         pend_ff <= vsum[SAMPLE_BITS-1:0];
      end
      if (out_load) begin
         out_ff.sample_out <= pend_ff;
         out_ff.run_last   <= cmd.finish;
         out_ff.buffer_end <= cmd.finish && last_ff;
      end
   end

   always_comb begin
      sts.div_busy   = div_busy;
      sts.on_base    = base_ff == target;
      sts.run_more   = (base_ff == target) && (cnt_ff < CNT_W'(MAX_UPSAMPLE))
                     && (!last_ff || (NUM_W'(given_ff) < cap_ff));
      sts.push_ok    = push_ok;
      sts.pend_valid = pend_valid_ff;
      sts.seen_zero  = seen_ff == '0;
      sts.last       = last_ff;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> push_ok)
      else $error("output register overwritten while stalled");

   a_residue_range: assert property (@(posedge clock) disable iff (reset)
      res_ff < orr_ff)
      else $error("phase residue not below output rate");

   a_run_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_UPSAMPLE))
      else $error("too many outputs on one base index");

endmodule

>>> hw/rtl/lir_ctrl.sv
// Controller FSM: sequences cap, interpolation and phase steps per transaction.
// Depends on lir_pkg; drives the datapath through cmd_type, reads sts_type.
module lir_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lir_pkg::sts_type  sts,
   output lir_pkg::cmd_type  cmd
);
   import lir_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_START     = 13'b0000000000010,
      S_CAP_MUL   = 13'b0000000000100,
      S_CAP_DIV   = 13'b0000000001000,
      S_CHECK     = 13'b0000000010000,
      S_INT_MUL   = 13'b0000000100000,
      S_INT_DIV   = 13'b0000001000000,
      S_EMIT      = 13'b0000010000000,
      S_ADV_DIV   = 13'b0000100000000,
      S_SKIP_DIV  = 13'b0001000000000,
      S_SKIP_MUL  = 13'b0010000000000,
      S_SKADV_DIV = 13'b0100000000000,
      S_FINISH    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      phase_ff, phase_in;
   logic      started_ff, started_in;
   logic      div_done;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      started_in    = started_ff;
      div_done      = started_ff && !sts.div_busy;
      req_ready     = 1'b0;
      cmd.take      = 1'b0;
      cmd.mul_go    = 1'b0;
      cmd.mul_sel   = MUL_CAP;
      cmd.div_go    = 1'b0;
      cmd.div_sel   = DIV_CAP;
      cmd.cap_load  = 1'b0;
      cmd.cnt_clear = 1'b0;
      cmd.emit      = 1'b0;
      cmd.adv_load  = 1'b0;
      cmd.m_load    = 1'b0;
      cmd.finish    = 1'b0;
      cmd.phase     = phase_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            if (sts.last) begin
               state_in = S_CAP_MUL;
            end else if (!sts.seen_zero) begin
               phase_in      = 1'b0;
               cmd.cnt_clear = 1'b1;
               state_in      = S_CHECK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_CAP_MUL: begin
            cmd.mul_sel = MUL_CAP;
            cmd.mul_go  = 1'b1;
            state_in    = S_CAP_DIV;
         end
         S_CAP_DIV: begin
            cmd.div_sel = DIV_CAP;
            cmd.div_go  = !started_ff;
            started_in  = 1'b1;
            if (div_done) begin
               started_in    = 1'b0;
               cmd.cap_load  = 1'b1;
               cmd.cnt_clear = 1'b1;
               phase_in      = sts.seen_zero;
               state_in      = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.run_more) begin
               state_in = S_INT_MUL;
            end else if (sts.on_base) begin
               state_in = S_SKIP_DIV;
            end else if (!phase_ff && sts.last) begin
               phase_in      = 1'b1;
               cmd.cnt_clear = 1'b1;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_INT_MUL: begin
            cmd.mul_sel = MUL_INTERP;
            cmd.mul_go  = 1'b1;
            state_in    = S_INT_DIV;
         end
         S_INT_DIV: begin
            cmd.div_sel = DIV_INTERP;
            cmd.div_go  = !started_ff;
            started_in  = 1'b1;
            if (div_done) begin
               started_in = 1'b0;
               state_in   = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!sts.pend_valid || sts.push_ok) begin
               cmd.emit = 1'b1;
               state_in = S_ADV_DIV;
            end
         end
         S_ADV_DIV: begin
            cmd.div_sel = DIV_ADV;
            cmd.div_go  = !started_ff;
            started_in  = 1'b1;
            if (div_done) begin
               started_in   = 1'b0;
               cmd.adv_load = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_SKIP_DIV: begin
            cmd.div_sel = DIV_SKIP;
            cmd.div_go  = !started_ff;
            started_in  = 1'b1;
            if (div_done) begin
               started_in = 1'b0;
               cmd.m_load = 1'b1;
               state_in   = S_SKIP_MUL;
            end
         end
         S_SKIP_MUL: begin
            cmd.mul_sel = MUL_SKIP;
            cmd.mul_go  = 1'b1;
            state_in    = S_SKADV_DIV;
         end
         S_SKADV_DIV: begin
            cmd.div_sel = DIV_SKADV;
            cmd.div_go  = !started_ff;
            started_in  = 1'b1;
            if (div_done) begin
               started_in   = 1'b0;
               cmd.adv_load = 1'b1;
               if (!phase_ff && sts.last) begin
                  phase_in      = 1'b1;
                  cmd.cnt_clear = 1'b1;
                  state_in      = S_CHECK;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (!sts.pend_valid || sts.push_ok) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         started_ff <= started_in;
      end
   end

   a_div_go_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_go |-> !sts.div_busy)
      else $error("divider started while busy");

   a_finish_push: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!sts.pend_valid || sts.push_ok))
      else $error("final result pushed into a full output register");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !sts.pend_valid)
      else $error("result left pending between transactions");

endmodule

>>> hw/rtl/linear_interp_resampler.sv
// Linear interpolation resampler, top level: lir_ctrl sequences lir_dp.
// Each transaction: per result, an interpolation multiply and divide, the emit
// and a phase divide; a base skip adds a skip divide, multiply and divide, and
// a buffer-last sample the cap multiply and divide. One transaction at a time.
// Reset: synchronous, active high; both rates 1, stream state cleared.
module linear_interp_resampler #(
   parameter int MAX_UPSAMPLE = lir_pkg::MAX_UPSAMPLE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  lir_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lir_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [lir_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lir_pkg::RATE_W-1:0]     csr_wdata
);
   import lir_pkg::*;

   cmd_type cmd;
   sts_type sts;

   lir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lir_dp #(
      .MAX_UPSAMPLE (MAX_UPSAMPLE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> dv/lir_stream_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the linear interpolation resampler: tracks rate writes and accepted
// request transactions, predicts the interpolated samples and checks each response.
// Depends on lir_pkg for the transaction types, widths and register codes.
module lir_stream_checker #(
   parameter int MAX_UPSAMPLE = lir_pkg::MAX_UPSAMPLE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  lir_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  lir_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [lir_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lir_pkg::RATE_W-1:0]     csr_wdata,
   output int unsigned                    mismatch_count,
   output int unsigned                    pending_count
);
   import lir_pkg::*;

   logic [RATE_W-1:0]              in_rate_q;
   logic [RATE_W-1:0]              out_rate_q;
   logic signed [SAMPLE_BITS-1:0]  prev_sample_q;
   logic [IDX_W-1:0]               seen_q;
   logic [IDX_W-1:0]               given_q;
   logic [IDX_W-1:0]               base_q;
   logic [RATE_W-1:0]              residue_q;
   rsp_type                        interp_expected_q[$];
   int unsigned                    errors = 0;
   int unsigned                    waiting = 0;

   assign mismatch_count = errors;
   assign pending_count  = waiting;

   task automatic restart_buffer();
      prev_sample_q = '0;
      seen_q        = '0;
      given_q       = '0;
      base_q        = '0;
      residue_q     = '0;
   endtask

   function automatic longint unsigned eff_rate(input logic [RATE_W-1:0] r);
      return (r == '0) ? 64'd1 : 64'(r);
   endfunction

   function automatic longint floor_quot(input longint num, input longint den);
      if (num >= 0)
         return num / den;
      return -(((-num) + den - 1) / den);
   endfunction

   task automatic step_phase(input longint unsigned steps, input longint unsigned ir,
                             input longint unsigned orr);
      longint unsigned acc;
      acc       = 64'(residue_q) + steps * ir;
      base_q    = base_q + IDX_W'(acc / orr);
      residue_q = RATE_W'(acc % orr);
   endtask

   // Outputs whose position falls between samples run_base and run_base+1.
   task automatic emit_base_run(input logic [IDX_W-1:0] run_base, input longint a,
                                input longint b, input longint unsigned cap,
                                input longint unsigned ir, input longint unsigned orr);
      int              emitted;
      longint          v;
      longint unsigned m;
      rsp_type         item;
      emitted = 0;
      while (base_q == run_base && emitted < MAX_UPSAMPLE && 64'(given_q) < cap) begin
         v = a + floor_quot((b - a) * longint'(residue_q), longint'(orr));
         item.sample_out = SAMPLE_BITS'(v);
         item.run_last   = 1'b0;
         item.buffer_end = 1'b0;
         interp_expected_q.push_back(item);
         emitted++;
         given_q = given_q + 1;
         step_phase(64'd1, ir, orr);
      end
      if (base_q == run_base) begin
         m = (orr - 64'(residue_q) + ir - 1) / ir;
         step_phase(m, ir, orr);
      end
   endtask

   task automatic resample_item(input req_type item);
      longint unsigned  ir;
      longint unsigned  orr;
      longint unsigned  cap;
      longint           cur;
      longint           prev;
      logic [IDX_W-1:0] k;
      int               first;
      rsp_type          tail;
      ir    = eff_rate(in_rate_q);
      orr   = eff_rate(out_rate_q);
      cur   = longint'($signed(item.sample_in));
      prev  = longint'(prev_sample_q);
      k     = seen_q;
      cap   = '1;
      first = interp_expected_q.size();
      if (item.buffer_last)
         cap = (64'(k) + 64'd1) * orr / ir;
      if (k != '0)
         emit_base_run(k - 1, prev, cur, cap, ir, orr);
      if (item.buffer_last)
         emit_base_run(k, cur, cur, cap, ir, orr);
      if (interp_expected_q.size() > first) begin
         tail = interp_expected_q.pop_back();
         tail.run_last = 1'b1;
         if (item.buffer_last)
            tail.buffer_end = 1'b1;
         interp_expected_q.push_back(tail);
      end
      if (item.buffer_last) begin
         restart_buffer();
      end else begin
         prev_sample_q = item.sample_in;
         seen_q        = k + 1;
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_item;
      if (reset) begin
         in_rate_q  = RATE_W'(1);
         out_rate_q = RATE_W'(1);
         restart_buffer();
         interp_expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (interp_expected_q.size() == 0) begin
               errors++;
               $display("%0t: no transaction expected, got sample %0d run_last %0b buffer_end %0b",
                        $time, $signed(rsp_data.sample_out), rsp_data.run_last,
                        rsp_data.buffer_end);
            end else begin
               exp_item = interp_expected_q.pop_front();
               if (rsp_data.sample_out !== exp_item.sample_out ||
                   rsp_data.run_last !== exp_item.run_last ||
                   rsp_data.buffer_end !== exp_item.buffer_end) begin
                  errors++;
                  $display("%0t: expected sample %0d run_last %0b buffer_end %0b, got sample %0d run_last %0b buffer_end %0b",
                           $time, $signed(exp_item.sample_out), exp_item.run_last,
                           exp_item.buffer_end, $signed(rsp_data.sample_out),
                           rsp_data.run_last, rsp_data.buffer_end);
               end
            end
         end
         if (csr_we) begin
            if (csr_index == REG_INPUT_RATE)
               in_rate_q = csr_wdata;
            else if (csr_index == REG_OUTPUT_RATE)
               out_rate_q = csr_wdata;
            restart_buffer();
         end
         if (req_valid && req_ready)
            resample_item(req_data);
      end
      waiting = interp_expected_q.size();
   end

endmodule

>>> dv/linear_interp_resampler_test.sv
`timescale 1ns / 100ps
// Top of the resampler testbench: clock, reset, rate writes and sample stimulus with
// random idling on both channels. Depends on lir_pkg, the block and lir_stream_checker.
module linear_interp_resampler_test;
   import lir_pkg::*;

   localparam int                SETTLE_CYCLES = 400;
   localparam int                STALL_LIMIT   = 20000;
   localparam int                PHASE_ITEMS   = 42;
   localparam logic [RATE_W-1:0] RATE_MAX      = '1;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [RATE_W-1:0]    csr_wdata;
   logic                 steady = 1'b0;
   int unsigned          mismatch_count;
   int unsigned          pending_count;

   linear_interp_resampler u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lir_stream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 27);
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic last);
      req_type item;
      while (!steady && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      item.sample_in   = s;
      item.buffer_last = last;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_buffer(input int len);
      for (int i = 0; i < len; i++)
         send_sample(pick_sample(), i == len - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [RATE_W-1:0] value);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_rates(input logic [RATE_W-1:0] ir, input logic [RATE_W-1:0] orr);
      write_reg(REG_INPUT_RATE, ir);
      write_reg(REG_OUTPUT_RATE, orr);
   endtask

   function automatic logic [RATE_W-1:0] pick_extreme_rate();
      case ($urandom_range(0, 2))
         0: return '0;
         1: return RATE_W'(1);
         default: return RATE_MAX;
      endcase
   endfunction

   initial begin
      int unsigned audio_rates[7];
      int unsigned ir;
      int unsigned orr;
      int unsigned hi;
      int          sent;
      int          pause_at;
      int          len;
      bit          paused;
      audio_rates = '{8000, 11025, 16000, 22050, 44100, 48000, 96000};
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = REG_INPUT_RATE;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset rates, sample extremes, then a single-sample buffer
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'h3039, 1'b1);
      // exact 16x upsampling, full swing: most results per transaction
      set_rates(8000, 128000);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b1);
      // beyond the upsampling limit
      set_rates(1, RATE_MAX);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h0064, 1'b1);
      // heavy downsampling: cap already exceeded, last sample emits nothing
      set_rates(RATE_MAX, 1);
      send_sample(16'h1234, 1'b0);
      send_sample(16'hEDCB, 1'b0);
      send_sample(16'h7FFF, 1'b1);
      // zero rates act as one
      set_rates(0, 0);
      send_sample(16'h0100, 1'b0);
      send_sample(16'hFF00, 1'b1);
      // rate write in the middle of a buffer restarts it
      write_reg(REG_OUTPUT_RATE, 3);
      send_sample(16'h03E8, 1'b0);
      send_sample(16'hFC18, 1'b0);
      write_reg(REG_INPUT_RATE, 2);
      send_sample(16'h0005, 1'b0);
      send_sample(16'hFFF9, 1'b1);

      for (int p = 0; p < 8; p++) begin
         case ($urandom_range(0, 9)) inside
            [0:5]: begin
               ir = $urandom_range(1, RATE_MAX);
               hi = (ir * 16 > RATE_MAX) ? RATE_MAX : ir * 16;
               orr = $urandom_range(0, 1) ? $urandom_range(1, ir) : $urandom_range(ir, hi);
            end
            [6:7]: begin
               ir  = audio_rates[$urandom_range(0, 6)];
               orr = audio_rates[$urandom_range(0, 6)];
            end
            8: begin
               ir  = $urandom_range(0, 8);
               orr = $urandom_range(0, 8);
            end
            default: begin
               ir  = pick_extreme_rate();
               orr = pick_extreme_rate();
            end
         endcase
         set_rates(RATE_W'(ir), RATE_W'(orr));
         steady   <= (p == 2);
         sent     = 0;
         paused   = 0;
         pause_at = $urandom_range(5, PHASE_ITEMS - 5);
         while (sent < PHASE_ITEMS) begin
            if (!paused && sent >= pause_at) begin
               drain();
               paused = 1;
            end
            if ($urandom_range(0, 99) < 85) begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
               send_buffer(len);
               sent += len;
            end else begin
               send_sample(pick_sample(), 1'($urandom_range(0, 1)));
               sent++;
            end
         end
      end

      drain();
      steady <= 1'b0;
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> linear_interp_resampler.f
hw/rtl/lir_pkg.sv
hw/rtl/lir_div.sv
hw/rtl/lir_dp.sv
hw/rtl/lir_ctrl.sv
hw/rtl/linear_interp_resampler.sv
dv/lir_stream_checker.sv
dv/linear_interp_resampler_test.sv
